[rtl/pmix_pkg.sv]
// ----------------------------------------------------------------------------
// pmix_pkg: shared types and constants of the polar to H-bridge mixer
// Field widths, register codes, reset values and the sine table builder.
// ----------------------------------------------------------------------------
package pmix_pkg;

    localparam int C_SPEED_W = 7;
    localparam int C_ANGLE_W = 9;
    localparam int C_DUTY_W  = 8;
    localparam int C_CONE_W  = 6;
    localparam int C_FS_W    = 8;
    localparam int C_CFG_IDX_W = 1;
    localparam int C_CFG_DATA_W = 8;

    localparam int C_SINE_FRACTION_BITS = 16;
    localparam int C_SINE_MAX_W = 25;
    localparam int C_WORK_BITS = 30;
    localparam logic [63:0] C_HALF_PI_Q30 = 64'd1686629713;

    // Drive level times full scale fits 15 bits; divide by 100 via 5243 / 2^19.
    localparam int C_SCALED_W = 15;
    localparam int C_RECIP_W = 13;
    localparam logic [C_RECIP_W-1:0] C_RECIP100 = 13'd5243;
    localparam int C_RECIP_SHIFT = 19;

    localparam logic [C_CONE_W-1:0] C_CONE_RESET = 6'd15;
    localparam logic [C_FS_W-1:0]   C_FS_RESET   = 8'd255;
    localparam logic [6:0]          C_LEVEL_MAX  = 7'd100;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_CONE = 1'b0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FS   = 1'b1;

    typedef struct packed {
        logic [C_CONE_W-1:0] cone_half_width;
        logic [C_FS_W-1:0]   pwm_full_scale;
    } t_cfg;

    typedef struct packed {
        logic [C_DUTY_W-1:0] duty_a1;
        logic [C_DUTY_W-1:0] duty_a2;
        logic [C_DUTY_W-1:0] duty_b1;
        logic [C_DUTY_W-1:0] duty_b2;
        logic                moving;
    } t_result;

    typedef logic [C_SINE_MAX_W-1:0] t_sine_tab [0:90];

    // Quarter-wave sine in Q1.fbits from a Taylor series in Q30 arithmetic.
    function automatic t_sine_tab build_sine(input int fbits);
        t_sine_tab          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        acc_u;
        logic signed [63:0] acc;
        int                 sh;
        sh = C_WORK_BITS - fbits;
        for (int k = 0; k <= 90; k++) begin
            x = (64'(k) * C_HALF_PI_Q30 + 64'd45) / 64'd90;
            x2 = (x * x) >> C_WORK_BITS;
            term = x;
            acc = signed'(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) >> C_WORK_BITS;
                case (n)
                    1: term = term / 64'd6;
                    2: term = term / 64'd20;
                    3: term = term / 64'd42;
                    4: term = term / 64'd72;
                    5: term = term / 64'd110;
                    6: term = term / 64'd156;
                    7: term = term / 64'd210;
                    default: term = term / 64'd272;
                endcase
                if (n[0]) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > (64'sd1 <<< C_WORK_BITS)) begin
                acc = 64'sd1 <<< C_WORK_BITS;
            end
            acc_u = unsigned'(acc) + (64'd1 << (sh - 1));
            tab[k] = C_SINE_MAX_W'(acc_u >> sh);
        end
        return tab;
    endfunction

endpackage

[rtl/pmix_ifs.sv]
// ----------------------------------------------------------------------------
// pmix_ifs: handshake channels of the polar to H-bridge mixer
// Command input, duty result output and register write channels.
// ----------------------------------------------------------------------------
interface pmix_in_if;
    import pmix_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [C_SPEED_W-1:0] speed;
    logic [C_ANGLE_W-1:0] angle;
    modport source (output valid, output speed, output angle, input ready);
    modport sink (input valid, input speed, input angle, output ready);
endinterface

interface pmix_out_if;
    import pmix_pkg::*;
    logic                valid;
    logic                ready;
    logic [C_DUTY_W-1:0] duty_a1;
    logic [C_DUTY_W-1:0] duty_a2;
    logic [C_DUTY_W-1:0] duty_b1;
    logic [C_DUTY_W-1:0] duty_b2;
    logic                moving;
    modport source (output valid, output duty_a1, output duty_a2, output duty_b1,
                    output duty_b2, output moving, input ready);
    modport sink (input valid, input duty_a1, input duty_a2, input duty_b1,
                  input duty_b2, input moving, output ready);
endinterface

interface pmix_cfg_if;
    import pmix_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [C_CFG_IDX_W-1:0]  index;
    logic [C_CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/pmix_mul.sv]
// ----------------------------------------------------------------------------
// pmix_mul: shared unsigned multiplier with registered product
// The product register loads only when the sequencer issues an operation.
// ----------------------------------------------------------------------------
module pmix_mul #(
    parameter int AW = 15,
    parameter int BW = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    logic [AW+BW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (AW+BW)'(i_a) * (AW+BW)'(i_b);
        end
    end

    assign o_p = r_p;
endmodule

[rtl/pmix_core.sv]
// ----------------------------------------------------------------------------
// pmix_core: sequencer and datapath of the polar to H-bridge mixer
// Runs trig products, scaling and divide-by-100 through one multiplier.
// ----------------------------------------------------------------------------
module pmix_core #(
    parameter int SINE_FRACTION_BITS = pmix_pkg::C_SINE_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmix_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pmix_pkg::C_SPEED_W-1:0] i_speed,
    input  logic [pmix_pkg::C_ANGLE_W-1:0] i_angle,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output pmix_pkg::t_result             o_res
);
    import pmix_pkg::*;

    localparam int SW = SINE_FRACTION_BITS + 1;
    localparam int BW = (SW > C_RECIP_W) ? SW : C_RECIP_W;
    localparam int AW = C_SCALED_W;
    localparam int PW = AW + BW;
    localparam t_sine_tab C_SINE = build_sine(SINE_FRACTION_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_F,
        S_MUL_T,
        S_SCALE_B,
        S_RECIP_B,
        S_SCALE_O,
        S_RECIP_O,
        S_WRITE
    } t_state;

    t_state               r_state;
    logic [C_SPEED_W-1:0] r_speed;
    logic [6:0]           r_idx_f;
    logic [6:0]           r_idx_t;
    logic                 r_neg_f;
    logic                 r_neg_t;
    logic                 r_cone_fwd;
    logic                 r_cone_rev;
    logic                 r_stop;
    logic [6:0]           r_fm;
    logic [6:0]           r_tm;
    logic [C_DUTY_W-1:0]  r_both;
    logic [C_DUTY_W-1:0]  r_held [4];
    logic [C_DUTY_W-1:0]  n_held [4];

    logic [C_ANGLE_W-1:0] ang_mod;
    logic [6:0]           idx_f;
    logic [6:0]           idx_t;
    logic                 neg_f;
    logic                 neg_t;
    logic [9:0]           ang10;
    logic [9:0]           cone10;
    logic                 cone_fwd;
    logic                 cone_rev;

    logic                 mul_en;
    logic [AW-1:0]        mul_a;
    logic [BW-1:0]        mul_b;
    logic [PW-1:0]        prod;
    logic [6:0]           trig;
    logic [7:0]           sum_b;
    logic [6:0]           lvl_b;
    logic [6:0]           lvl_o;
    logic [C_DUTY_W-1:0]  scaled;
    logic                 f_pos;
    logic                 f_neg;
    logic                 t_pos;
    logic                 t_neg;

    pmix_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Fold the angle into a quadrant and pick the table indices and signs.
    always_comb begin
        ang_mod = (i_angle >= 9'd360) ? i_angle - 9'd360 : i_angle;
        if (ang_mod < 9'd90) begin
            idx_f = 7'(ang_mod);
            idx_t = 7'(9'd90 - ang_mod);
            neg_f = 1'b0;
            neg_t = 1'b0;
        end else if (ang_mod < 9'd180) begin
            idx_f = 7'(9'd180 - ang_mod);
            idx_t = 7'(ang_mod - 9'd90);
            neg_f = 1'b0;
            neg_t = 1'b1;
        end else if (ang_mod < 9'd270) begin
            idx_f = 7'(ang_mod - 9'd180);
            idx_t = 7'(9'd270 - ang_mod);
            neg_f = 1'b1;
            neg_t = 1'b1;
        end else begin
            idx_f = 7'(9'd360 - ang_mod);
            idx_t = 7'(ang_mod - 9'd270);
            neg_f = 1'b1;
            neg_t = 1'b0;
        end
    end

    // The cone tests use the raw angle, not the folded one.
    assign ang10    = {1'b0, i_angle};
    assign cone10   = 10'(i_cfg.cone_half_width);
    assign cone_fwd = (ang10 <= cone10) || (ang10 >= 10'd360 - cone10);
    assign cone_rev = (ang10 >= 10'd180 - cone10) && (ang10 <= 10'd180 + cone10);

    assign trig   = prod[SINE_FRACTION_BITS +: 7];
    assign sum_b  = {1'b0, r_fm} + {1'b0, trig};
    assign lvl_b  = (sum_b > 8'(C_LEVEL_MAX)) ? C_LEVEL_MAX : sum_b[6:0];
    assign lvl_o  = (r_fm > C_LEVEL_MAX) ? C_LEVEL_MAX : r_fm;
    assign scaled = prod[C_RECIP_SHIFT +: C_DUTY_W];

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_MUL_F: begin
                mul_a = AW'(r_speed);
                mul_b = BW'(C_SINE[r_idx_f][SW-1:0]);
            end
            S_MUL_T: begin
                mul_a = AW'(r_speed);
                mul_b = BW'(C_SINE[r_idx_t][SW-1:0]);
            end
            S_SCALE_B: begin
                mul_a = AW'(lvl_b);
                mul_b = BW'(i_cfg.pwm_full_scale);
            end
            S_SCALE_O: begin
                mul_a = AW'(lvl_o);
                mul_b = BW'(i_cfg.pwm_full_scale);
            end
            S_RECIP_B, S_RECIP_O: begin
                mul_a = prod[AW-1:0];
                mul_b = BW'(C_RECIP100);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // In the write state the product holds the single-side duty.
    assign f_pos = !r_neg_f && (r_fm != 7'd0);
    assign f_neg = r_neg_f && (r_fm != 7'd0);
    assign t_pos = !r_neg_t && (r_tm != 7'd0);
    assign t_neg = r_neg_t && (r_tm != 7'd0);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_held[i] = r_held[i];
        end
        if (r_stop) begin
            for (int i = 0; i < 4; i++) begin
                n_held[i] = '0;
            end
        end else if (r_cone_fwd) begin
            n_held[0] = '0;
            n_held[1] = r_both;
            n_held[2] = r_both;
            n_held[3] = '0;
        end else if (r_cone_rev) begin
            n_held[0] = r_both;
            n_held[1] = '0;
            n_held[2] = '0;
            n_held[3] = r_both;
        end else if (f_neg && t_pos) begin
            n_held[0] = r_both;
            n_held[1] = '0;
            n_held[2] = scaled;
            n_held[3] = '0;
        end else if (f_neg && t_neg) begin
            n_held[0] = scaled;
            n_held[1] = '0;
            n_held[2] = r_both;
            n_held[3] = '0;
        end else if (f_pos && t_pos) begin
            n_held[0] = '0;
            n_held[1] = r_both;
            n_held[2] = '0;
            n_held[3] = scaled;
        end else if (f_pos && t_neg) begin
            n_held[0] = '0;
            n_held[1] = scaled;
            n_held[2] = '0;
            n_held[3] = r_both;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < 4; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_speed    <= i_speed;
                        r_idx_f    <= idx_f;
                        r_idx_t    <= idx_t;
                        r_neg_f    <= neg_f;
                        r_neg_t    <= neg_t;
                        r_cone_fwd <= cone_fwd;
                        r_cone_rev <= cone_rev;
                        r_stop     <= (i_speed == '0);
                        r_state    <= (i_speed == '0) ? S_WRITE : S_MUL_F;
                    end
                end
                S_MUL_F: begin
                    r_state <= S_MUL_T;
                end
                S_MUL_T: begin
                    r_fm    <= trig;
                    r_state <= S_SCALE_B;
                end
                S_SCALE_B: begin
                    r_tm    <= trig;
                    r_state <= S_RECIP_B;
                end
                S_RECIP_B: begin
                    r_state <= S_SCALE_O;
                end
                S_SCALE_O: begin
                    r_both  <= scaled;
                    r_state <= S_RECIP_O;
                end
                S_RECIP_O: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (i_res_ready) begin
                        for (int i = 0; i < 4; i++) begin
                            r_held[i] <= n_held[i];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_res_valid   = (r_state == S_WRITE);
    assign o_res.duty_a1 = n_held[0];
    assign o_res.duty_a2 = n_held[1];
    assign o_res.duty_b1 = n_held[2];
    assign o_res.duty_b2 = n_held[3];
    assign o_res.moving  = !r_stop;
endmodule

[rtl/polar_to_hbridge_pwm_mixer.sv]
// ----------------------------------------------------------------------------
// polar_to_hbridge_pwm_mixer: joystick speed and angle to four H-bridge duties
// Holds the registers, the result register and the mixing core.
// ----------------------------------------------------------------------------
// Sequence: a moving command steps through S_MUL_F, S_MUL_T, S_SCALE_B,
// S_RECIP_B, S_SCALE_O and S_RECIP_O to S_WRITE, a stop command straight to
// S_WRITE. The six operations share the single multiplier, so no new command
// is taken until S_WRITE hands the last one to the result register.
// Reset: synchronous, active low; held duties clear, registers return to
// cone 15 and full scale 255.
module polar_to_hbridge_pwm_mixer #(
    parameter int SINE_FRACTION_BITS = pmix_pkg::C_SINE_FRACTION_BITS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    pmix_in_if.sink    i_in,
    pmix_out_if.source o_out,
    pmix_cfg_if.sink   i_cfg
);
    import pmix_pkg::*;

    t_cfg    r_cfg;
    t_result r_out;
    logic    r_out_valid;
    t_result core_res;
    logic    core_valid;
    logic    slot_ready;
    logic    core_in_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cone_half_width <= C_CONE_RESET;
            r_cfg.pwm_full_scale  <= C_FS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                C_REG_CONE: r_cfg.cone_half_width <= i_cfg.data[C_CONE_W-1:0];
                C_REG_FS:   r_cfg.pwm_full_scale  <= i_cfg.data[C_FS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pmix_core #(.SINE_FRACTION_BITS(SINE_FRACTION_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (core_in_ready),
        .i_speed     (i_in.speed),
        .i_angle     (i_in.angle),
        .o_res_valid (core_valid),
        .i_res_ready (slot_ready),
        .o_res       (core_res)
    );

    assign i_in.ready = core_in_ready;

    // The core hands over a word only when the result register is empty or being drained.
    assign slot_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_ready) begin
            r_out_valid <= core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_ready && core_valid) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.duty_a1 = r_out.duty_a1;
    assign o_out.duty_a2 = r_out.duty_a2;
    assign o_out.duty_b1 = r_out.duty_b1;
    assign o_out.duty_b2 = r_out.duty_b2;
    assign o_out.moving  = r_out.moving;

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.moving |->
            (r_out.duty_a1 == '0) && (r_out.duty_a2 == '0) &&
            (r_out.duty_b1 == '0) && (r_out.duty_b2 == '0))
        else $error("stopped word carries a nonzero duty");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("core ready again right after accepting a word");

    a_core_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_valid && !slot_ready |=> core_valid)
        else $error("core dropped a word while the result register was full");
endmodule
